// ===== hw/rtl/stable_merge_sort_macros.svh =====
// Assertion macros used by the merge sort RTL.
`ifndef STABLE_MERGE_SORT_MACROS_SVH
`define STABLE_MERGE_SORT_MACROS_SVH

// Same-cycle implication, checked on clk_i, masked while in reset.
`define SMS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("merge sort: same-cycle check failed");

// Next-cycle implication, checked on clk_i, masked while in reset.
`define SMS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("merge sort: next-cycle check failed");

`endif

// ===== hw/rtl/sms_pkg.sv =====
// Types and constants of the stable merge sort block.
package sms_pkg;

  localparam int unsigned MAX_ITEMS = 64;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int unsigned ADDR_W    = $clog2(MAX_ITEMS);
  localparam int unsigned SUM_W     = CNT_W + 1;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
    logic                     truncated;
  } out_item_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_RUN,
    S_RDA,
    S_RDB,
    S_MRG,
    S_FILL,
    S_OREAD,
    S_OEMIT
  } state_e;

endpackage

// ===== hw/rtl/sms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/stable_merge_sort.sv =====
// Stable merge sort: loads a set, sorts it bottom-up between two RAMs, streams it out.
// Loading accepts one item per cycle; busy_o stays low until the item marked last.
// Sorting: ceil(log2 N) passes; per run pair S_RUN, S_RDA and S_RDB, per element S_MRG
//   and S_FILL, limited by the single read port of the source RAM.
// Output: each result is read, then strobed for one cycle; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) empties the open set; RAM contents are not cleared.
module stable_merge_sort (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  sms_pkg::in_item_t item_i,
  output logic              res_strobe_o,
  output sms_pkg::out_item_t res_o
);
  import sms_pkg::*;

  `include "stable_merge_sort_macros.svh"

  state_e state_q, state_d;

  // Set bookkeeping.
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic [CNT_W-1:0] n_q, n_d;

  // Merge pass registers: run width, pair base, run heads, bounds, write index.
  logic [CNT_W-1:0] width_q, width_d;
  logic [CNT_W-1:0] lo_q, lo_d;
  logic [CNT_W-1:0] a_q, a_d;
  logic [CNT_W-1:0] b_q, b_d;
  logic [CNT_W-1:0] mid_q, mid_d;
  logic [CNT_W-1:0] hi_q, hi_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic [DATA_W-1:0] ha_q, ha_d;
  logic [DATA_W-1:0] hb_q, hb_d;
  logic             side_q, side_d;   // 1: head A is being refilled
  logic             dir_q, dir_d;     // 0: source is the element store

  out_item_t res_q, res_d;
  logic      res_vld_q, res_vld_d;

  // RAM ports.
  logic              we0, we1;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] rdata0, rdata1, rdata_src;

  // Helpers.
  logic             accept, full;
  logic [CNT_W-1:0] count_inc;
  logic [SUM_W-1:0] lo_w, lo_2w, width_2;
  logic [CNT_W-1:0] mid_c, hi_c;
  logic             a_live, b_live, take_a, run_done, pass_done, sort_done;
  logic [CNT_W-1:0] a_inc, b_inc, k_inc;

  assign accept    = start_i && (state_q == S_LOAD);
  assign full      = (count_q == CNT_W'(MAX_ITEMS));
  assign count_inc = full ? count_q : count_q + CNT_W'(1);

  assign lo_w    = {1'b0, lo_q} + {1'b0, width_q};
  assign width_2 = {1'b0, width_q} << 1;
  assign lo_2w   = {1'b0, lo_q} + width_2;
  assign mid_c   = (lo_w  > {1'b0, n_q}) ? n_q : lo_w[CNT_W-1:0];
  assign hi_c    = (lo_2w > {1'b0, n_q}) ? n_q : lo_2w[CNT_W-1:0];

  assign a_live   = (a_q < mid_q);
  assign b_live   = (b_q < hi_q);
  // Left run wins on equal values: this keeps the sort stable.
  assign take_a   = a_live && (!b_live || ($signed(ha_q) <= $signed(hb_q)));
  assign run_done = !a_live && !b_live;
  // The next pair base is lo + 2w; every pair of this pass is done once it reaches n.
  assign pass_done = (lo_2w >= {1'b0, n_q});
  assign sort_done = (width_2 >= {1'b0, n_q});

  assign a_inc = a_q + CNT_W'(1);
  assign b_inc = b_q + CNT_W'(1);
  assign k_inc = k_q + CNT_W'(1);

  assign rdata_src = dir_q ? rdata1 : rdata0;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD: begin
        if (accept && item_i.last) begin
          state_d = (count_inc <= CNT_W'(1)) ? S_OREAD : S_RUN;
        end
      end
      S_RUN:  state_d = S_RDA;
      S_RDA:  state_d = S_RDB;
      S_RDB:  state_d = S_MRG;
      S_MRG: begin
        if (!run_done) begin
          state_d = S_FILL;
        end else if (pass_done && sort_done) begin
          state_d = S_OREAD;
        end else begin
          state_d = S_RUN;
        end
      end
      S_FILL:  state_d = S_MRG;
      S_OREAD: state_d = S_OEMIT;
      S_OEMIT: state_d = (k_inc == n_q) ? S_LOAD : S_OREAD;
      default: state_d = S_LOAD;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    count_d   = count_q;
    ovf_d     = ovf_q;
    n_d       = n_q;
    width_d   = width_q;
    lo_d      = lo_q;
    a_d       = a_q;
    b_d       = b_q;
    mid_d     = mid_q;
    hi_d      = hi_q;
    k_d       = k_q;
    ha_d      = ha_q;
    hb_d      = hb_q;
    side_d    = side_q;
    dir_d     = dir_q;
    res_d     = res_q;
    res_vld_d = 1'b0;
    we0       = 1'b0;
    we1       = 1'b0;
    waddr     = k_q[ADDR_W-1:0];
    wdata     = take_a ? ha_q : hb_q;
    raddr     = '0;

    unique case (state_q)
      S_LOAD: begin
        waddr = count_q[ADDR_W-1:0];
        wdata = item_i.value;
        if (accept) begin
          we0     = !full;
          count_d = count_inc;
          ovf_d   = ovf_q | full;
          if (item_i.last) begin
            n_d     = count_inc;
            width_d = CNT_W'(1);
            lo_d    = '0;
            k_d     = '0;
            dir_d   = 1'b0;
          end
        end
      end
      S_RUN: begin
        raddr = lo_q[ADDR_W-1:0];
        mid_d = mid_c;
        hi_d  = hi_c;
        a_d   = lo_q;
        b_d   = mid_c;
        k_d   = lo_q;
      end
      S_RDA: begin
        ha_d  = rdata_src;
        raddr = mid_q[ADDR_W-1:0];  // points past the set when the right run is empty; never used then
      end
      S_RDB: begin
        hb_d = rdata_src;
      end
      S_MRG: begin
        if (!run_done) begin
          we0    = dir_q;
          we1    = !dir_q;
          k_d    = k_inc;
          side_d = take_a;
          if (take_a) begin
            a_d   = a_inc;
            raddr = a_inc[ADDR_W-1:0];
          end else begin
            b_d   = b_inc;
            raddr = b_inc[ADDR_W-1:0];
          end
        end else if (pass_done) begin
          dir_d   = !dir_q;
          lo_d    = '0;
          width_d = width_2[CNT_W-1:0];
          k_d     = '0;
        end else begin
          lo_d = lo_2w[CNT_W-1:0];
        end
      end
      S_FILL: begin
        if (side_q) begin
          ha_d = rdata_src;
        end else begin
          hb_d = rdata_src;
        end
      end
      S_OREAD: begin
        raddr = k_q[ADDR_W-1:0];
      end
      S_OEMIT: begin
        res_vld_d          = 1'b1;
        res_d.sorted_value = rdata_src;
        res_d.final_res    = (k_inc == n_q);
        res_d.truncated    = ovf_q;
        k_d                = k_inc;
        if (k_inc == n_q) begin
          count_d = '0;
          ovf_d   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      res_vld_q <= 1'b0;
      dir_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      res_vld_q <= res_vld_d;
      dir_q     <= dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    width_q <= width_d;
    lo_q    <= lo_d;
    a_q     <= a_d;
    b_q     <= b_d;
    mid_q   <= mid_d;
    hi_q    <= hi_d;
    k_q     <= k_d;
    ha_q    <= ha_d;
    hb_q    <= hb_d;
    side_q  <= side_d;
    res_q   <= res_d;
  end

  // Element store: loaded on arrival, then source of even passes.
  sms_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_store (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata0)
  );

  // Merge buffer: destination of even passes, source of odd ones.
  sms_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_buffer (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata1)
  );

  assign busy_o       = (state_q != S_LOAD);
  assign res_strobe_o = res_vld_q;
  assign res_o        = res_q;

  // A merge write never lands past the end of its run pair.
  `SMS_ASSERT_IMP(a_merge_bound, (state_q == S_MRG) && !run_done, k_q < hi_q)
  // Run heads never pass their bounds.
  `SMS_ASSERT_IMP(a_head_bound, state_q == S_MRG, (a_q <= mid_q) && (b_q <= hi_q))
  // The final result leaves an empty set behind.
  `SMS_ASSERT_IMP(a_final_clear, res_vld_q && res_q.final_res, count_q == '0 && !ovf_q)
  // Closing a set makes the block busy.
  `SMS_ASSERT_NXT(a_last_busy, accept && item_i.last, busy_o)

endmodule
